### hdl/lrl_pkg.sv
// Package for the LRU recency list: register map, field widths and reset values.
`default_nettype none
package lrl_pkg;

  // Payload field widths.
  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned OCC_W = 5;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CAP_W      = 5;

  localparam logic [APB_ADDR_W-1:0] REG_CAPACITY_ADDR = APB_ADDR_W'(0);
  localparam logic [CAP_W-1:0]      CAPACITY_RESET    = CAP_W'(16);

  // Defaults for the top-level parameters.
  localparam int unsigned DEFAULT_DEPTH    = 16;
  localparam int unsigned DEFAULT_KEY_BITS = 32;

endpackage : lrl_pkg
`default_nettype wire

### hdl/lru_recency_list.sv
// LRU recency list: a fully associative store of keys kept in recency order.
//
// Usage: each request on the input channel (key_i, start_new_i) is looked up
// against every held key at once. A hit moves the key to rank 0; a miss inserts
// it at rank 0 and, when the list already holds the configured capacity, drops
// the least recent key. start_new_i empties the list before the lookup. Every
// request yields exactly one result (hit, rank before the access, eviction,
// dropped key and occupancy afterwards) on the output channel.
// A request accepted into the input register moves on to the result register
// once that register is free. Throughput: one request per cycle while results are taken; the
// lookup, the one-place shift of the key cells and the count update settle in
// the single stage between the input register and the result register.
// Stalls: while a result waits on out_ready_i the input register still takes
// a request; when both are full, in_ready_o drops until the result is taken.
// Reset empties the list and sets capacity to 16; key cells are not cleared,
// only ranks below the occupancy are ever compared. capacity (APB offset 0) must be
// written only while the block is idle, which it does not enforce; 0 acts as 1, above DEPTH as DEPTH.
`default_nettype none
module lru_recency_list #(
  parameter int unsigned DEPTH    = lrl_pkg::DEFAULT_DEPTH,
  parameter int unsigned KEY_BITS = lrl_pkg::DEFAULT_KEY_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // APB configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrl_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [lrl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [lrl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  // Input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [lrl_pkg::KEY_W-1:0] key_i,
  input  wire logic                            start_new_i,
  // Output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 hit_o,
  output logic      [lrl_pkg::POS_W-1:0]       hit_position_o,
  output logic                                 evicted_o,
  output logic signed [lrl_pkg::KEY_W-1:0]     evicted_key_o,
  output logic      [lrl_pkg::OCC_W-1:0]       occupancy_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration register.
  logic [lrl_pkg::CAP_W-1:0] cap_q;
  logic                      cap_we;

  // Input register.
  logic                s1_valid_q, s1_valid_d;
  logic [KEY_BITS-1:0] s1_key_q;
  logic                s1_start_q;
  logic                s1_load;

  // Recency state.
  logic [KEY_BITS-1:0] cells_q [DEPTH];
  logic [KEY_BITS-1:0] cells_d [DEPTH];
  logic [CNT_W-1:0]    held_q, held_d;

  // Result register.
  logic                      out_valid_q, out_valid_d;
  logic                      hit_q, evicted_q;
  logic [lrl_pkg::POS_W-1:0] pos_q;
  logic [lrl_pkg::KEY_W-1:0] ev_key_q;
  logic [lrl_pkg::OCC_W-1:0] occ_q;

  // Update logic.
  logic                      advance, fire;
  logic [63:0]               key_wide;
  logic [CNT_W-1:0]          cap_eff, held_eff, held_m1, shift_upto;
  logic [DEPTH-1:0]          match;
  logic                      hit_c, full_c;
  logic [IDX_W-1:0]          pos_c;
  logic [63:0]               ev_wide, pos_wide, occ_wide;

  // ---------------------------------------------------------------------------
  // APB port
  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && (paddr == lrl_pkg::REG_CAPACITY_ADDR);

  always_comb begin
    prdata = '0;
    if (paddr == lrl_pkg::REG_CAPACITY_ADDR) begin
      prdata = lrl_pkg::APB_DATA_W'(cap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lrl_pkg::CAPACITY_RESET;
    end else if (cap_we) begin
      cap_q <= pwdata[lrl_pkg::CAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign s1_load    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  // Keys are held in their low KEY_BITS bits.
  assign key_wide = 64'(unsigned'(key_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_key_q   <= key_wide[KEY_BITS-1:0];
      s1_start_q <= start_new_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup and reorder
  always_comb begin
    cap_eff = CNT_W'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > int'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end
  end

  assign held_eff = s1_start_q ? '0 : held_q;
  assign held_m1  = held_eff - CNT_W'(1);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CNT_W'(i) < held_eff) && (cells_q[i] == s1_key_q);
    end
  end

  // The lowest matching rank wins.
  always_comb begin
    pos_c = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos_c = IDX_W'(i);
      end
    end
  end

  assign hit_c  = |match;
  assign full_c = !hit_c && (held_eff >= cap_eff);

  // Ranks 1..shift_upto take the key one rank more recent; rank 0 takes the key.
  always_comb begin
    if (hit_c) begin
      shift_upto = CNT_W'(pos_c);
    end else if (full_c) begin
      shift_upto = cap_eff - CNT_W'(1);
    end else begin
      shift_upto = held_eff;
    end
  end

  always_comb begin
    cells_d[0] = s1_key_q;
    for (int i = 1; i < DEPTH; i++) begin
      cells_d[i] = (CNT_W'(i) <= shift_upto) ? cells_q[i-1] : cells_q[i];
    end
  end

  always_comb begin
    if (hit_c) begin
      held_d = held_eff;
    end else if (full_c) begin
      held_d = cap_eff;
    end else begin
      held_d = held_eff + CNT_W'(1);
    end
  end

  assign ev_wide  = full_c ? 64'(cells_q[held_m1[IDX_W-1:0]]) : '0;
  assign pos_wide = 64'(pos_c);
  assign occ_wide = 64'(held_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (fire) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q     <= hit_c;
      pos_q     <= pos_wide[lrl_pkg::POS_W-1:0];
      evicted_q <= full_c;
      ev_key_q  <= ev_wide[lrl_pkg::KEY_W-1:0];
      occ_q     <= occ_wide[lrl_pkg::OCC_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign hit_position_o = pos_q;
  assign evicted_o      = evicted_q;
  assign evicted_key_o  = signed'(ev_key_q);
  assign occupancy_o    = occ_q;

  // ---------------------------------------------------------------------------
  // Assertions
  held_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(DEPTH))
    else $error("occupancy exceeds the number of key cells");

  hit_no_evict_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && evicted_q))
    else $error("a result reports both a hit and an eviction");

  start_leaves_one_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_start_q) |=> (held_q == CNT_W'(1)))
    else $error("a new run does not leave exactly one key");

  hit_keeps_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && hit_c) |=> (held_q == $past(held_q)))
    else $error("a hit changed the occupancy");

  stall_holds_result_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(held_q)))
    else $error("state moved while a result was stalled");

endmodule : lru_recency_list
`default_nettype wire

### sim/lru_recency_list_tb.sv
// Testbench for lru_recency_list: directed and random accesses checked against a recency predictor.
module lru_recency_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = lrl_pkg::DEFAULT_DEPTH;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned POOL_SIZE   = 24;

  typedef struct packed {
    logic                      hit;
    logic [lrl_pkg::POS_W-1:0] position;
    logic                      evicted;
    logic [lrl_pkg::KEY_W-1:0] evicted_key;
    logic [lrl_pkg::OCC_W-1:0] occupancy;
  } lookup_result_t;

  typedef struct packed {
    logic [lrl_pkg::KEY_W-1:0] key;
    logic                      start_new;
    logic                      typed;
    lookup_result_t            want;
  } access_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [lrl_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [lrl_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lrl_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic signed [lrl_pkg::KEY_W-1:0] key_i = '0;
  logic                             start_new_i = 1'b0;

  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic                             hit_o;
  logic [lrl_pkg::POS_W-1:0]        hit_position_o;
  logic                             evicted_o;
  logic signed [lrl_pkg::KEY_W-1:0] evicted_key_o;
  logic [lrl_pkg::OCC_W-1:0]        occupancy_o;

  lru_recency_list u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_i          (key_i),
    .start_new_i    (start_new_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .hit_position_o (hit_position_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the list, ordered by recency, and of the capacity register.
  logic [lrl_pkg::KEY_W-1:0] recency [DEPTH];
  int unsigned               held_keys = 0;
  logic [lrl_pkg::CAP_W-1:0] cap_setting = lrl_pkg::CAPACITY_RESET;

  lookup_result_t            expected_results [$];
  logic [lrl_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned    failures = 0;
  int unsigned    in_accepts = 0;
  int unsigned    apb_writes = 0;
  int unsigned    stall_cycles = 0;
  bit             steady = 1'b0;
  bit             typed_next = 1'b0;
  lookup_result_t typed_want = '0;

  // Keys are written as unsigned bit patterns; 32'h8000_0000 is the most negative key.
  access_row_t directed_rows [23] = '{
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 5'd1}},
    '{32'h8000_0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 5'd2}},
    '{32'h0000_0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 5'd3}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 5'd4}},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, '{1'b1, 4'd3, 1'b0, 32'h0, 5'd4}},
    '{32'h8000_0000, 1'b0, 1'b1, '{1'b1, 4'd3, 1'b0, 32'h0, 5'd4}},
    '{32'h8000_0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 32'h0, 5'd4}},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h0000_0004, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0006, 1'b0, 1'b0, '0},
    '{32'h0000_0007, 1'b0, 1'b0, '0},
    '{32'h0000_0008, 1'b0, 1'b0, '0},
    '{32'h0000_0009, 1'b0, 1'b0, '0},
    '{32'h0000_000A, 1'b0, 1'b0, '0},
    '{32'h0000_000B, 1'b0, 1'b0, '0},
    '{32'h0000_000C, 1'b0, 1'b0, '0},
    // The list is full here and the zero key is the least recent one.
    '{32'h0000_0000, 1'b0, 1'b1, '{1'b1, 4'd15, 1'b0, 32'h0, 5'd16}},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 5'd1}},
    '{32'hAAAA_AAAA, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0, 5'd1}}
  };

  logic [lrl_pkg::CAP_W-1:0] phase_caps [NUM_PHASES] = '{
    5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd16, 5'd9, 5'd12
  };

  function automatic lookup_result_t predict_access(logic [lrl_pkg::KEY_W-1:0] key,
                                                    logic start_new);
    lookup_result_t r;
    int unsigned    limit;
    int unsigned    held;
    int unsigned    upto;
    bit             found;
    r = '0;
    found = 1'b0;
    limit = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
    if (start_new) held_keys = 0;
    held = held_keys;
    for (int unsigned i = 0; i < held; i++) begin
      if (!found && recency[i] == key) begin
        found = 1'b1;
        r.position = lrl_pkg::POS_W'(i);
      end
    end
    if (found) begin
      r.hit = 1'b1;
      upto = r.position;
    end else if (held >= limit) begin
      // Also covers a capacity lowered below the occupancy: everything past
      // the new limit falls off, and the least recent held key is reported.
      r.evicted = 1'b1;
      r.evicted_key = recency[held-1];
      upto = limit - 1;
      held = limit;
    end else begin
      upto = held;
      held = held + 1;
    end
    for (int unsigned i = upto; i > 0; i--) recency[i] = recency[i-1];
    recency[0] = key;
    held_keys = held;
    r.occupancy = lrl_pkg::OCC_W'(held);
    return r;
  endfunction

  function automatic void check_field(string name, logic [lrl_pkg::KEY_W-1:0] want,
                                      logic [lrl_pkg::KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    lookup_result_t want;
    bit             progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", lrl_pkg::KEY_W'(want.hit), lrl_pkg::KEY_W'(hit_o));
          check_field("hit_position", lrl_pkg::KEY_W'(want.position),
                      lrl_pkg::KEY_W'(hit_position_o));
          check_field("evicted", lrl_pkg::KEY_W'(want.evicted), lrl_pkg::KEY_W'(evicted_o));
          check_field("evicted_key", want.evicted_key, evicted_key_o);
          check_field("occupancy", lrl_pkg::KEY_W'(want.occupancy),
                      lrl_pkg::KEY_W'(occupancy_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        progress = 1'b1;
        want = predict_access(key_i, start_new_i);
        expected_results.push_back(typed_next ? typed_want : want);
        in_accepts++;
      end
      if (psel && penable && pwrite && pready) begin
        progress = 1'b1;
        if (paddr == lrl_pkg::REG_CAPACITY_ADDR) cap_setting = pwdata[lrl_pkg::CAP_W-1:0];
        apb_writes++;
      end
    end
    stall_cycles = progress ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 28);
  end

  // Presents one request and returns at the falling edge after it is taken,
  // with valid still high so the next request can follow without a gap.
  task automatic send_access(logic [lrl_pkg::KEY_W-1:0] key, logic start_new, logic typed,
                             lookup_result_t want);
    int unsigned seen;
    while (!steady && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    typed_next = typed;
    typed_want = want;
    in_valid_i <= 1'b1;
    key_i <= key;
    start_new_i <= start_new;
    seen = in_accepts;
    do @(negedge clk_i); while (in_accepts == seen);
  endtask

  task automatic write_capacity(logic [lrl_pkg::CAP_W-1:0] value);
    int unsigned seen;
    seen = apb_writes;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= lrl_pkg::REG_CAPACITY_ADDR;
    pwdata <= lrl_pkg::APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (apb_writes == seen);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    logic [lrl_pkg::KEY_W-1:0] key;
    logic                      start_new;
    int unsigned               pick;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part runs at the reset capacity.
    foreach (directed_rows[i]) begin
      send_access(directed_rows[i].key, directed_rows[i].start_new,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      while (expected_results.size() != 0) @(negedge clk_i);
      write_capacity((ph >= 8) ? lrl_pkg::CAP_W'($urandom_range(1, 31)) : phase_caps[ph]);
      steady = (ph == 6 || ph == 7);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // The largest share are keys already held, so hits land on every rank and the
        // list stays full; the rest are pool repeats and fresh keys.
        pick = $urandom_range(99);
        if (pick < 45 && held_keys > 0) key = recency[$urandom_range(held_keys - 1)];
        else if (pick < 80) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else key = $urandom();
        start_new = ($urandom_range(99) < 2);
        send_access(key, start_new, 1'b0, '0);
      end
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
